// ===== rtl/fnpll_pkg.sv =====
// ----------------------------------------------------------------------------
// Fractional-N PLL divider calculation package
// Channel divider table, selection thresholds and constants for the
// divide-by-10 MHz step.
// ----------------------------------------------------------------------------
`default_nettype none

package fnpll_pkg;

	localparam int NumDiv = 18;
	localparam int IdxW = 5;
	localparam int DivW = 10;
	localparam int FreqW = 34;
	localparam int VcoW = 35;
	localparam int NIntW = 12;
	localparam int NNumW = 24;

	// 10 MHz = 2^7 * 78125; the low seven bits bypass the divider.
	localparam int PfdShift = 7;
	localparam int OddW = 17;
	localparam logic [OddW-1:0] PfdOdd = 17'd78125;
	localparam logic [NNumW-1:0] PfdStep = 24'd10000000;

	// Reciprocal floor(2^40 / 78125); the estimate is low by at most one.
	localparam int RecipShift = 40;
	localparam int RecipW = 24;
	localparam logic [RecipW-1:0] RecipM = 24'd14073748;

	typedef logic [DivW-1:0] div_table_t [NumDiv];
	typedef logic [FreqW-1:0] thr_table_t [NumDiv];

	localparam div_table_t DivTable = '{
		10'd2, 10'd4, 10'd6, 10'd8, 10'd12, 10'd16, 10'd24, 10'd32, 10'd48,
		10'd64, 10'd72, 10'd96, 10'd128, 10'd192, 10'd256, 10'd384, 10'd512,
		10'd768
	};

	// Each entry is floor(7.5 GHz / divider).
	localparam thr_table_t ThrTable = '{
		34'd3750000000, 34'd1875000000, 34'd1250000000, 34'd937500000,
		34'd625000000, 34'd468750000, 34'd312500000, 34'd234375000,
		34'd156250000, 34'd117187500, 34'd104166666, 34'd78125000,
		34'd58593750, 34'd39062500, 34'd29296875, 34'd19531250,
		34'd14648437, 34'd9765625
	};

endpackage

`default_nettype wire

// ===== rtl/frac_n_pll_divider_calc.sv =====
// ----------------------------------------------------------------------------
// Fractional-N PLL divider calculation
// Picks the channel divider for a requested output frequency and splits the
// VCO frequency into the integer and fractional feedback divider values.
//
// Usage: drive output_frequency_hz and raise start for one cycle per item.
// busy is always low, so an item is accepted at every edge with start high,
// one item per clock cycle sustained. Each item gives one result, registered
// through the stages below: done is high for one cycle with
// divider_index, channel_divider, n_integer and n_numerator. The receiver
// cannot stall, and results are presented in acceptance order.
// Stages: divider select, VCO multiply, reciprocal multiply for the
// divide by 78125, back multiply and subtract, and a single correction
// step. Each step has its own register stage.
// Reset empties the pipeline; items in flight are dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module frac_n_pll_divider_calc (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               start,
	output logic                                    busy,
	input  wire logic [fnpll_pkg::FreqW-1:0]        output_frequency_hz,
	output logic                                    done,
	output logic      [fnpll_pkg::IdxW-1:0]         divider_index,
	output logic      [fnpll_pkg::DivW-1:0]         channel_divider,
	output logic      [fnpll_pkg::NIntW-1:0]        n_integer,
	output logic      [fnpll_pkg::NNumW-1:0]        n_numerator
);

	localparam int VHiW = fnpll_pkg::VcoW - fnpll_pkg::PfdShift;
	localparam int RemW = fnpll_pkg::OddW + 1;
	localparam int QdW = fnpll_pkg::NIntW + fnpll_pkg::OddW;

	logic v_s1, v_s2, v_s3, v_s4, v_s5;

	logic [fnpll_pkg::IdxW-1:0] idx_sel;
	logic [fnpll_pkg::FreqW-1:0] freq_s1;
	logic [fnpll_pkg::IdxW-1:0] idx_s1, idx_s2, idx_s3, idx_s4, idx_s5;
	logic [fnpll_pkg::DivW-1:0] div_s1, div_s2, div_s3, div_s4, div_s5;

	logic [fnpll_pkg::FreqW+fnpll_pkg::DivW-1:0] vco_full;
	logic [fnpll_pkg::VcoW-1:0] vco_s2;

	logic [VHiW+fnpll_pkg::RecipW-1:0] qprod;
	logic [VHiW-1:0] vhi_s3;
	logic [fnpll_pkg::PfdShift-1:0] vlo_s3, vlo_s4, vlo_s5;
	logic [fnpll_pkg::NIntW-1:0] q_s3, q_s4, q_s5;

	logic [QdW-1:0] qd;
	logic [QdW-1:0] rem_full;
	logic [RemW-1:0] rem_s4;

	logic rem_ge;
	logic [RemW-1:0] rem_corr;
	logic [fnpll_pkg::OddW-1:0] rem_s5;

	assign busy = 1'b0;

	always_comb begin
		idx_sel = '0;
		for (int i = fnpll_pkg::NumDiv - 1; i >= 0; i--) begin
			if (output_frequency_hz >= fnpll_pkg::ThrTable[i]) begin
				idx_sel = fnpll_pkg::IdxW'(i);
			end
		end
	end

	assign vco_full = freq_s1 * div_s1;
	assign qprod = vco_s2[fnpll_pkg::VcoW-1:fnpll_pkg::PfdShift] * fnpll_pkg::RecipM;
	assign qd = q_s3 * fnpll_pkg::PfdOdd;
	assign rem_full = QdW'(vhi_s3) - qd;
	assign rem_ge = rem_s4 >= RemW'(fnpll_pkg::PfdOdd);
	assign rem_corr = rem_ge ? (rem_s4 - RemW'(fnpll_pkg::PfdOdd)) : rem_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s1 <= start && !busy;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		freq_s1 <= output_frequency_hz;
		idx_s1 <= idx_sel;
		div_s1 <= fnpll_pkg::DivTable[idx_sel];

		vco_s2 <= vco_full[fnpll_pkg::VcoW-1:0];
		idx_s2 <= idx_s1;
		div_s2 <= div_s1;

		q_s3 <= qprod[fnpll_pkg::RecipShift+fnpll_pkg::NIntW-1:fnpll_pkg::RecipShift];
		vhi_s3 <= vco_s2[fnpll_pkg::VcoW-1:fnpll_pkg::PfdShift];
		vlo_s3 <= vco_s2[fnpll_pkg::PfdShift-1:0];
		idx_s3 <= idx_s2;
		div_s3 <= div_s2;

		rem_s4 <= rem_full[RemW-1:0];
		q_s4 <= q_s3;
		vlo_s4 <= vlo_s3;
		idx_s4 <= idx_s3;
		div_s4 <= div_s3;

		rem_s5 <= rem_corr[fnpll_pkg::OddW-1:0];
		q_s5 <= rem_ge ? (q_s4 + 1'b1) : q_s4;
		vlo_s5 <= vlo_s4;
		idx_s5 <= idx_s4;
		div_s5 <= div_s4;
	end

	assign done = v_s5;
	assign divider_index = idx_s5;
	assign channel_divider = div_s5;
	assign n_integer = q_s5;
	assign n_numerator = {rem_s5, vlo_s5};

	// Every accepted item comes out as a result.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##5 done)
		else $error("accepted item did not produce a result after five cycles");

	// Nothing comes out that was not accepted.
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 5))
		else $error("result without an accepted item");

	// The reciprocal estimate is never more than one step low.
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 |-> rem_s4 < RemW'(2 * 78125))
		else $error("quotient estimate out of range");

	a_num_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> n_numerator < fnpll_pkg::PfdStep)
		else $error("fractional numerator not below the denominator");

	a_div_match: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> divider_index < fnpll_pkg::IdxW'(fnpll_pkg::NumDiv) &&
			channel_divider == fnpll_pkg::DivTable[divider_index])
		else $error("divider value does not match its index");

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the fractional-N PLL divider calculation
// Drives a short table of directed frequencies (zero, the fallback below
// every threshold, each divider threshold, the field maximum) and then
// random frequencies with random gaps and back-to-back bursts. Every result
// is compared field by field with a predicted channel divider and N value.
// ----------------------------------------------------------------------------

module testbench;

	localparam int WatchdogLimit = 1000;
	localparam int DrainCycles = 12;
	localparam int RandomItems = 1850;

	typedef struct packed {
		logic [fnpll_pkg::IdxW-1:0]  idx;
		logic [fnpll_pkg::DivW-1:0]  div;
		logic [fnpll_pkg::NIntW-1:0] nint;
		logic [fnpll_pkg::NNumW-1:0] nnum;
	} pll_setting_t;

	typedef struct {
		logic [fnpll_pkg::FreqW-1:0] freq;
		bit                          typed;
		pll_setting_t                setting;
	} freq_row_t;

	logic                           clk;
	logic                           arst_n;
	logic                           start;
	logic                           busy;
	logic [fnpll_pkg::FreqW-1:0]    output_frequency_hz;
	logic                           done;
	logic [fnpll_pkg::IdxW-1:0]     divider_index;
	logic [fnpll_pkg::DivW-1:0]     channel_divider;
	logic [fnpll_pkg::NIntW-1:0]    n_integer;
	logic [fnpll_pkg::NNumW-1:0]    n_numerator;

	pll_setting_t expected_settings[$];
	freq_row_t    freq_table[$];
	int           mismatches;
	int           items_sent;
	int           results_seen;
	int           idle_cycles;
	bit           index_hit [fnpll_pkg::NumDiv];

	frac_n_pll_divider_calc DUT (
		.clk                 (clk),
		.arst_n              (arst_n),
		.start               (start),
		.busy                (busy),
		.output_frequency_hz (output_frequency_hz),
		.done                (done),
		.divider_index       (divider_index),
		.channel_divider     (channel_divider),
		.n_integer           (n_integer),
		.n_numerator         (n_numerator)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic logic [fnpll_pkg::DivW-1:0] chan_div(int k);
		case (k)
			0: chan_div = 10'd2;
			1: chan_div = 10'd4;
			2: chan_div = 10'd6;
			3: chan_div = 10'd8;
			4: chan_div = 10'd12;
			5: chan_div = 10'd16;
			6: chan_div = 10'd24;
			7: chan_div = 10'd32;
			8: chan_div = 10'd48;
			9: chan_div = 10'd64;
			10: chan_div = 10'd72;
			11: chan_div = 10'd96;
			12: chan_div = 10'd128;
			13: chan_div = 10'd192;
			14: chan_div = 10'd256;
			15: chan_div = 10'd384;
			16: chan_div = 10'd512;
			default: chan_div = 10'd768;
		endcase
	endfunction

	function automatic logic [63:0] div_threshold(int k);
		logic [63:0] d;
		d = {54'd0, chan_div(k)};
		div_threshold = 64'd7500000000 / d;
	endfunction

	function automatic pll_setting_t calc_pll_setting(logic [fnpll_pkg::FreqW-1:0] f);
		pll_setting_t r;
		logic [63:0]  f64;
		logic [63:0]  d64;
		logic [63:0]  vco;
		int           sel;
		bit           found;
		sel = 0;
		found = 1'b0;
		f64 = {30'd0, f};
		for (int k = 0; k < fnpll_pkg::NumDiv; k++) begin
			if (!found && f64 >= div_threshold(k)) begin
				sel = k;
				found = 1'b1;
			end
		end
		d64 = {54'd0, chan_div(sel)};
		vco = f64 * d64;
		r.idx = sel[fnpll_pkg::IdxW-1:0];
		r.div = chan_div(sel);
		r.nint = fnpll_pkg::NIntW'(vco / 64'd10000000);
		r.nnum = fnpll_pkg::NNumW'(vco % 64'd10000000);
		calc_pll_setting = r;
	endfunction

	task automatic report_mismatch(string what);
		$display("[%0t] MISMATCH %s", $time, what);
		mismatches++;
	endtask

	task automatic add_row(logic [fnpll_pkg::FreqW-1:0] f, bit typed, int idx, int div,
			int nint, int nnum);
		freq_row_t row;
		row.freq = f;
		row.typed = typed;
		row.setting.idx = idx[fnpll_pkg::IdxW-1:0];
		row.setting.div = div[fnpll_pkg::DivW-1:0];
		row.setting.nint = nint[fnpll_pkg::NIntW-1:0];
		row.setting.nnum = nnum[fnpll_pkg::NNumW-1:0];
		freq_table.push_back(row);
	endtask

	// Hands one item to the block and holds start until it is taken.
	task automatic send_freq(logic [fnpll_pkg::FreqW-1:0] f, bit typed, pll_setting_t want,
			int gap);
		@(negedge clk);
		start <= 1'b1;
		output_frequency_hz <= f;
		forever begin
			@(posedge clk);
			if (!busy) break;
		end
		expected_settings.push_back(typed ? want : calc_pll_setting(f));
		items_sent++;
		if (gap > 0) begin
			@(negedge clk);
			start <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	function automatic logic [fnpll_pkg::FreqW-1:0] random_freq();
		logic [fnpll_pkg::FreqW-1:0] f;
		logic [63:0]                 thr;
		int                          pick;
		pick = $urandom_range(0, 9);
		case (pick)
			0, 1: f = {2'($urandom_range(0, 3)), $urandom()};
			2, 3: begin
				f = {2'($urandom_range(0, 3)), $urandom()};
				if (f > 34'd15000000000) f = f - 34'd15000000000;
			end
			4, 5, 6: begin
				thr = div_threshold($urandom_range(0, fnpll_pkg::NumDiv - 1));
				f = fnpll_pkg::FreqW'(thr + 64'($urandom_range(0, 8)) - 64'd4);
			end
			7: f = fnpll_pkg::FreqW'($urandom_range(0, 9765625));
			8: f = fnpll_pkg::FreqW'($urandom_range(9765625, 400000000));
			default: f = fnpll_pkg::FreqW'(64'($urandom_range(1, 1500)) * 64'd5000000
					+ 64'($urandom_range(0, 4)) - 64'd2);
		endcase
		random_freq = f;
	endfunction

	always @(posedge clk) begin : check_results
		pll_setting_t want;
		if (done) begin
			results_seen++;
			if (expected_settings.size() == 0) begin
				report_mismatch("result with no item outstanding");
			end else begin
				want = expected_settings.pop_front();
				if (divider_index !== want.idx)
					report_mismatch($sformatf("divider_index: got %0d, expected %0d",
							divider_index, want.idx));
				if (channel_divider !== want.div)
					report_mismatch($sformatf("channel_divider: got %0d, expected %0d",
							channel_divider, want.div));
				if (n_integer !== want.nint)
					report_mismatch($sformatf("n_integer: got %0d, expected %0d",
							n_integer, want.nint));
				if (n_numerator !== want.nnum)
					report_mismatch($sformatf("n_numerator: got %0d, expected %0d",
							n_numerator, want.nnum));
				if (want.idx < fnpll_pkg::NumDiv) index_hit[want.idx] = 1'b1;
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || done) begin
			idle_cycles <= 0;
		end else if (idle_cycles + 1 >= WatchdogLimit) begin
			$display("Timeout after %0d cycles with no item or result", WatchdogLimit);
			$display("Simulation FAILED");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin : stimulus
		pll_setting_t none;
		int           gap;
		bit           burst;
		int           hit_count;
		none = '0;
		items_sent = 0;
		burst = 1'b0;
		hit_count = 0;
		for (int k = 0; k < fnpll_pkg::NumDiv; k++) index_hit[k] = 1'b0;
		start = 1'b0;
		output_frequency_hz = '0;
		arst_n = 1'b0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		add_row(34'd0, 1'b1, 0, 2, 0, 0);
		add_row(34'd1, 1'b1, 0, 2, 0, 2);
		// Just below the smallest threshold: nothing fits, divider 2 is used.
		add_row(34'd9765624, 1'b1, 0, 2, 1, 9531248);
		add_row(34'd9765625, 1'b1, 17, 768, 750, 0);
		add_row(34'd3750000000, 1'b1, 0, 2, 750, 0);
		add_row(34'd15000000000, 1'b1, 0, 2, 3000, 0);
		add_row(34'h3FFFFFFFF, 1'b1, 0, 2, 3435, 9738366);
		add_row(34'd3749999999, 1'b0, 0, 0, 0, 0);
		add_row(34'd14648436, 1'b0, 0, 0, 0, 0);
		for (int k = 1; k < fnpll_pkg::NumDiv - 1; k++)
			add_row(fnpll_pkg::FreqW'(div_threshold(k)), 1'b0, 0, 0, 0, 0);

		foreach (freq_table[i])
			send_freq(freq_table[i].freq, freq_table[i].typed, freq_table[i].setting,
					$urandom_range(0, 2));

		for (int n = 0; n < RandomItems; n++) begin
			if (n % 40 == 0) burst = ($urandom_range(0, 3) == 0);
			gap = burst ? 0 : $urandom_range(0, 11);
			send_freq(random_freq(), 1'b0, none, gap);
		end

		@(negedge clk);
		start <= 1'b0;
		while (expected_settings.size() != 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);

		if (expected_settings.size() != 0) begin
			report_mismatch($sformatf("%0d items never produced a result",
					expected_settings.size()));
		end
		for (int k = 0; k < fnpll_pkg::NumDiv; k++) if (index_hit[k]) hit_count++;
		$display("Sent %0d frequencies and checked %0d results, %0d mismatches.",
				items_sent, results_seen, mismatches);
		$display("Channel dividers selected: %0d of %0d table entries.", hit_count,
				fnpll_pkg::NumDiv);
		if (mismatches == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
